[hw/rtl/bds_pkg.sv]
`timescale 1ns / 1ps

package bds_pkg;

    // fixed field widths
    localparam int INDEX_W   = 7;
    localparam int MASS_W    = 24;
    localparam int WIDTH_W   = 24;
    localparam int INV_W     = 32;
    localparam int DENSITY_W = 48;
    localparam int COUNT_W   = 8;
    localparam int FAR_BIT   = 24;

    // divider operand widths for round(2^48 / w^2)
    localparam int NUM_W = 49;
    localparam int DEN_W = 48;

    // round(2/pi * 2^32)
    localparam logic [31:0] K_TWO_OVER_PI = 32'hA2F9836E;

    // density clamp limits, signed Q32.16
    localparam logic [DENSITY_W-1:0] SUM_MAX = {1'b0, {(DENSITY_W-1){1'b1}}};
    localparam logic [DENSITY_W-1:0] SUM_MIN = {1'b1, {(DENSITY_W-1){1'b0}}};

    // controller -> datapath commands
    typedef struct packed {
        logic load_item;
        logic wsq_load;
        logic div_start;
        logic commit;
        logic walk_issue;
        logic out_load;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic is_eval;
        logic div_done;
        logic walk_last;
        logic pipe_busy;
    } t_sts;

    // per-stage tag through the evaluate pipeline
    typedef struct packed {
        logic v;
        logic ok;
        logic neg;
    } t_tag;

endpackage

[hw/rtl/bds_if.sv]
`timescale 1ns / 1ps

// input channel: one beat is a write or an evaluate item
interface bds_in_if #(
    parameter int COORD_BITS = 24
);
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [bds_pkg::INDEX_W-1:0]    entry_index;
    logic                           entry_enable;
    logic                           entry_negative;
    logic signed [COORD_BITS-1:0]   pos_x;
    logic signed [COORD_BITS-1:0]   pos_y;
    logic [bds_pkg::MASS_W-1:0]     entry_mass;
    logic [bds_pkg::WIDTH_W-1:0]    entry_width;

    modport source (
        output valid, command, entry_index, entry_enable, entry_negative,
               pos_x, pos_y, entry_mass, entry_width,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, entry_enable, entry_negative,
               pos_x, pos_y, entry_mass, entry_width,
        output ready
    );
endinterface

// output channel: one result beat per input item
interface bds_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bds_pkg::DENSITY_W-1:0] density;
    logic                                saturated;
    logic [bds_pkg::COUNT_W-1:0]         active_entries;

    modport source (output valid, density, saturated, active_entries, input ready);
    modport sink   (input  valid, density, saturated, active_entries, output ready);
endinterface

[hw/rtl/bds_ram.sv]
`timescale 1ns / 1ps

// simple dual-port RAM, one write port, one registered read port
module bds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/bds_div.sv]
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module bds_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bds_pkg::NUM_W-1:0]    i_num,
    input  logic [bds_pkg::DEN_W-1:0]    i_den,
    output logic [bds_pkg::NUM_W-1:0]    o_quo,
    output logic                         o_done
);

    localparam int NW   = bds_pkg::NUM_W;
    localparam int DW   = bds_pkg::DEN_W;
    localparam int CNTW = $clog2(NW);

    logic [NW-1:0]   r_rem, n_rem;
    logic [NW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [NW-1:0]   rem_sh;
    logic            fits;

    // shift in one numerator bit, trial subtract
    always_comb begin
        rem_sh = {r_rem[NW-2:0], r_quo[NW-1]};
        fits   = rem_sh >= NW'(r_den);
        n_rem  = fits ? (rem_sh - NW'(r_den)) : rem_sh;
        n_quo  = {r_quo[NW-2:0], fits};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

[hw/rtl/bds_dpath.sv]
`timescale 1ns / 1ps

// item registers, blob table, 1/w^2 divider and the evaluate pipeline
module bds_dpath #(
    parameter int MAX_ENTRIES = 128,
    parameter int COORD_BITS  = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bds_pkg::t_cmd                          i_cmd,
    output bds_pkg::t_sts                          o_sts,
    input  logic                                   i_command,
    input  logic [bds_pkg::INDEX_W-1:0]            i_entry_index,
    input  logic                                   i_entry_enable,
    input  logic                                   i_entry_negative,
    input  logic signed [COORD_BITS-1:0]           i_pos_x,
    input  logic signed [COORD_BITS-1:0]           i_pos_y,
    input  logic [bds_pkg::MASS_W-1:0]             i_entry_mass,
    input  logic [bds_pkg::WIDTH_W-1:0]            i_entry_width,
    output logic signed [bds_pkg::DENSITY_W-1:0]   o_density,
    output logic                                   o_saturated,
    output logic [bds_pkg::COUNT_W-1:0]            o_active_entries
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
    localparam int DIFW  = COORD_BITS + 1;
    localparam int MW    = bds_pkg::MASS_W;
    localparam int IW    = bds_pkg::INV_W;
    localparam int SW    = bds_pkg::DENSITY_W;
    localparam int RW    = 2 * COORD_BITS + MW + IW + 1;
    localparam int NSTG  = 10;
    // table word layout
    localparam int CY_LO   = COORD_BITS;
    localparam int INV_LO  = 2 * COORD_BITS;
    localparam int MASS_LO = INV_LO + IW;
    localparam int NEG_BIT = MASS_LO + MW;

    // ---------------- item registers ----------------
    logic                          r_is_eval;
    logic [bds_pkg::INDEX_W-1:0]   r_idx;
    logic                          r_ien;
    logic                          r_ineg;
    logic signed [COORD_BITS-1:0]  r_px;
    logic signed [COORD_BITS-1:0]  r_py;
    logic [MW-1:0]                 r_mass;
    logic [bds_pkg::WIDTH_W-1:0]   r_width;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_is_eval <= i_command;
            r_idx     <= i_entry_index;
            r_ien     <= i_entry_enable;
            r_ineg    <= i_entry_negative;
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_mass    <= i_entry_mass;
            r_width   <= i_entry_width;
        end
    end

    // ---------------- write path: w^2 and 1/w^2 ----------------
    logic [bds_pkg::DEN_W-1:0] r_wsq;
    logic [bds_pkg::NUM_W-1:0] div_num;
    logic [bds_pkg::NUM_W-1:0] div_quo;
    logic                      div_done;
    logic                      inv_sat;
    logic [IW-1:0]             inv_val;
    logic                      in_range;
    logic [AW-1:0]             wr_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wsq_load) begin
            r_wsq <= bds_pkg::DEN_W'(r_width) * bds_pkg::DEN_W'(r_width);
        end
    end

    // 2^48 + w^2/2 gives round half up
    assign div_num = (bds_pkg::NUM_W'(1) << 48) + bds_pkg::NUM_W'(r_wsq >> 1);

    bds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_wsq),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    assign inv_sat  = (r_wsq == '0) || (div_quo[bds_pkg::NUM_W-1:IW] != '0);
    assign inv_val  = inv_sat ? {IW{1'b1}} : div_quo[IW-1:0];
    assign in_range = 32'(r_idx) < 32'(MAX_ENTRIES);
    assign wr_addr  = AW'(r_idx);

    // ---------------- enable bits and count ----------------
    logic [MAX_ENTRIES-1:0] r_en;
    logic [CNTW-1:0]        r_count;
    logic                   r_wsat;
    logic                   commit_ok;

    assign commit_ok = i_cmd.commit && in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= '0;
            r_count <= '0;
        end else if (commit_ok) begin
            r_en[wr_addr] <= r_ien;
            r_count       <= r_count - CNTW'(r_en[wr_addr]) + CNTW'(r_ien);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_wsat <= in_range && inv_sat;
        end
    end

    // ---------------- blob table ----------------
    logic [AW-1:0] r_walk;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;

    assign ram_wdata = {r_ineg, r_mass, inv_val, r_py, r_px};

    bds_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (commit_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (i_cmd.walk_issue),
        .i_rd_addr (r_walk),
        .o_rd_data (ram_rdata)
    );

    // walk counter, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= '0;
        end else if (i_cmd.load_item) begin
            r_walk <= '0;
        end else if (i_cmd.walk_issue) begin
            r_walk <= r_walk + 1'b1;
        end
    end

    // ---------------- evaluate pipeline ----------------
    bds_pkg::t_tag r_tag [NSTG];

    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [DIFW-1:0]       dx;
    logic signed [DIFW-1:0]       dy;
    logic [DIFW-1:0]              adx;
    logic [DIFW-1:0]              ady;
    logic [33:0]                  adx_w;
    logic [33:0]                  ady_w;
    logic                         far;

    // stage 1: distance per axis, far test
    assign cx    = ram_rdata[COORD_BITS-1:0];
    assign cy    = ram_rdata[CY_LO +: COORD_BITS];
    assign dx    = DIFW'(r_px) - DIFW'(cx);
    assign dy    = DIFW'(r_py) - DIFW'(cy);
    assign adx   = dx[DIFW-1] ? DIFW'(-dx) : DIFW'(dx);
    assign ady   = dy[DIFW-1] ? DIFW'(-dy) : DIFW'(dy);
    assign adx_w = 34'(adx);
    assign ady_w = 34'(ady);
    assign far   = (adx_w[33:bds_pkg::FAR_BIT] != '0) || (ady_w[33:bds_pkg::FAR_BIT] != '0);

    logic [23:0]   r_adx, r_ady;
    logic [47:0]   r_sqx, r_sqy;
    logic [48:0]   r_rsq;
    logic [56:0]   r_ph;
    logic [55:0]   r_pl;
    logic [47:0]   r_p48;
    logic [24:0]   r_t24;
    logic [56:0]   r_bm;
    logic [57:0]   r_cm;
    logic [49:0]   r_tm;
    logic [IW-1:0] r_inv [1:7];
    logic [MW-1:0] r_ms  [1:8];

    logic [80:0] p_full;
    logic        in_blob;
    logic [49:0] t_full;
    logic [57:0] b_full;
    logic [25:0] b_val;
    logic [58:0] c_full;
    logic [25:0] c_val;

    always_comb begin
        p_full  = {r_ph, 24'd0} + 81'(r_pl);
        in_blob = p_full[80:48] == '0;
        t_full  = (50'd1 << 48) - 50'(r_p48) + (50'd1 << 23);
        b_full  = 58'(r_bm) + (58'd1 << 31);
        b_val   = b_full[57:32];
        c_full  = 59'(r_cm) + (59'd1 << 31);
        c_val   = c_full[57:32];
    end

    // tags: valid, takes part, negative
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag[0].v   <= i_cmd.walk_issue;
            r_tag[0].ok  <= r_en[r_walk];
            r_tag[0].neg <= 1'b0;
            r_tag[1].v   <= r_tag[0].v;
            r_tag[1].ok  <= r_tag[0].ok && !far;
            r_tag[1].neg <= ram_rdata[NEG_BIT];
            for (int k = 2; k < NSTG; k++) begin
                if (k != 5) begin
                    r_tag[k] <= r_tag[k-1];
                end
            end
            // stage 5 drops points outside the blob radius
            r_tag[5].v   <= r_tag[4].v;
            r_tag[5].ok  <= r_tag[4].ok && in_blob;
            r_tag[5].neg <= r_tag[4].neg;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_adx  <= adx_w[23:0];
        r_ady  <= ady_w[23:0];
        r_inv[1] <= ram_rdata[INV_LO +: IW];
        r_ms[1]  <= ram_rdata[MASS_LO +: MW];
        for (int k = 2; k <= 7; k++) begin
            r_inv[k] <= r_inv[k-1];
        end
        for (int k = 2; k <= 8; k++) begin
            r_ms[k] <= r_ms[k-1];
        end
        r_sqx <= 48'(r_adx) * 48'(r_adx);
        r_sqy <= 48'(r_ady) * 48'(r_ady);
        r_rsq <= 49'(r_sqx) + 49'(r_sqy);
        r_ph  <= 57'(r_rsq[48:24]) * 57'(r_inv[3]);
        r_pl  <= 56'(r_rsq[23:0]) * 56'(r_inv[3]);
        r_p48 <= p_full[47:0];
        r_t24 <= t_full[48:24];
        r_bm  <= 57'(r_t24) * 57'(r_inv[6]);
        r_cm  <= 58'(b_val) * 58'(bds_pkg::K_TWO_OVER_PI);
        r_tm  <= 50'(c_val) * 50'(r_ms[8]);
    end

    // ---------------- accumulate with clamp ----------------
    logic signed [SW-1:0] r_sum;
    logic                 r_sat;
    logic [50:0]          term_full;
    logic [38:0]          term;
    logic signed [SW:0]   sterm;
    logic signed [SW:0]   sum_ext;
    logic                 ovf;

    always_comb begin
        term_full = 51'(r_tm) + (51'd1 << 11);
        term      = term_full[50:12];
        sterm     = r_tag[NSTG-1].neg ? -(SW+1)'(term) : (SW+1)'(term);
        sum_ext   = (SW+1)'(r_sum) + sterm;
        ovf       = sum_ext[SW] != sum_ext[SW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_sum <= '0;
            r_sat <= 1'b0;
        end else if (r_tag[NSTG-1].v && r_tag[NSTG-1].ok) begin
            if (ovf) begin
                r_sum <= sum_ext[SW] ? bds_pkg::SUM_MIN : bds_pkg::SUM_MAX;
                r_sat <= 1'b1;
            end else begin
                r_sum <= sum_ext[SW-1:0];
            end
        end
    end

    // ---------------- result register ----------------
    logic signed [SW-1:0]         r_density;
    logic                         r_osat;
    logic [bds_pkg::COUNT_W-1:0]  r_ocount;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_density <= r_is_eval ? r_sum : '0;
            r_osat    <= r_is_eval ? r_sat : r_wsat;
            r_ocount  <= bds_pkg::COUNT_W'(r_count);
        end
    end

    assign o_density        = r_density;
    assign o_saturated      = r_osat;
    assign o_active_entries = r_ocount;

    // ---------------- status ----------------
    logic busy;
    always_comb begin
        busy = 1'b0;
        for (int k = 0; k < NSTG; k++) begin
            busy = busy | r_tag[k].v;
        end
    end

    assign o_sts.is_eval   = r_is_eval;
    assign o_sts.div_done  = div_done;
    assign o_sts.walk_last = r_walk == AW'(MAX_ENTRIES - 1);
    assign o_sts.pipe_busy = busy;

endmodule

[hw/rtl/bds_ctrl.sv]
`timescale 1ns / 1ps

// sequencer: accept, write via divider, or walk the table, then hand off result
module bds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bds_pkg::t_cmd  o_cmd,
    input  bds_pkg::t_sts  i_sts
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_WSTART   = 3'd2;
    localparam logic [2:0] S_WDIV     = 3'd3;
    localparam logic [2:0] S_WCOMMIT  = 3'd4;
    localparam logic [2:0] S_EWALK    = 3'd5;
    localparam logic [2:0] S_EDRAIN   = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]    r_state, n_state;
    logic          r_out_valid, n_out_valid;
    bds_pkg::t_cmd cmd;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.is_eval) begin
                    n_state = S_EWALK;
                end else begin
                    cmd.wsq_load = 1'b1;
                    n_state      = S_WSTART;
                end
            end
            S_WSTART: begin
                cmd.div_start = 1'b1;
                n_state       = S_WDIV;
            end
            S_WDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_WCOMMIT;
                end
            end
            S_WCOMMIT: begin
                cmd.commit = 1'b1;
                n_state    = S_DONE;
            end
            S_EWALK: begin
                cmd.walk_issue = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_EDRAIN;
                end
            end
            S_EDRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // result slot free or being emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // accepted beat always goes to dispatch
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISPATCH))
        else $error("accepted beat did not reach dispatch");

    // nothing left in flight once idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.pipe_busy)
        else $error("evaluate pipeline busy while idle");

    // divider finishes only while waited on
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_WDIV))
        else $error("divider done outside wait state");

    // table walk only for evaluate items
    a_walk_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWALK) |-> i_sts.is_eval)
        else $error("table walk for a write item");

endmodule

[hw/rtl/blob_density_sum.sv]
`timescale 1ns / 1ps

// Blob density table and evaluator. A write beat (command 0) loads one table
// slot with centre, mass, width and flags and computes round(2^48/width^2)
// with a bit-serial divider of 49 steps. A write to a slot at or above
// MAX_ENTRIES changes nothing. An evaluate beat (command 1) walks every slot,
// one per cycle, through a 10-stage multiply pipeline and sums the signed
// Q32.16 densities with saturation, then waits for the pipeline to drain.
// One item is worked on at a time; each item gives one result beat, held in
// an output register so the next item may be accepted before it is taken.
module blob_density_sum #(
    parameter int MAX_ENTRIES = 128,
    parameter int COORD_BITS  = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bds_in_if.sink         i_in,
    bds_out_if.source      o_out
);

    bds_pkg::t_cmd cmd;
    bds_pkg::t_sts sts;

    bds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bds_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_command        (i_in.command),
        .i_entry_index    (i_in.entry_index),
        .i_entry_enable   (i_in.entry_enable),
        .i_entry_negative (i_in.entry_negative),
        .i_pos_x          (i_in.pos_x),
        .i_pos_y          (i_in.pos_y),
        .i_entry_mass     (i_in.entry_mass),
        .i_entry_width    (i_in.entry_width),
        .o_density        (o_out.density),
        .o_saturated      (o_out.saturated),
        .o_active_entries (o_out.active_entries)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    typedef struct {
        bit        command;
        bit [6:0]  index;
        bit        enable;
        bit        negative;
        bit [23:0] px;
        bit [23:0] py;
        bit [23:0] mass;
        bit [23:0] width;
    } blob_item_t;

    typedef struct {
        bit [47:0] density;
        bit        saturated;
        bit [7:0]  active;
    } density_result_t;

    localparam longint LIMIT_CYCLES = 400000;

    logic i_clk;
    logic i_rst_n;

    bds_in_if  #(.COORD_BITS(24)) in_ch ();
    bds_out_if out_ch ();

    blob_density_sum #(.MAX_ENTRIES(128), .COORD_BITS(24)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor copy of the blob table
    longint    tbl_cx [128];
    longint    tbl_cy [128];
    bit [23:0] tbl_mass [128];
    bit [31:0] tbl_inv [128];
    bit        tbl_en [128];
    bit        tbl_neg [128];
    int        live_count;

    blob_item_t      pending_items[$];
    density_result_t expected_results[$];

    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off_cycles;
    bit     send_pause;
    int     mismatches;
    longint cycle_count;

    // unsigned Q.16 magnitude of one blob at the point
    function automatic bit [63:0] blob_magnitude(int i, longint x, longint y);
        longint    dx;
        longint    dy;
        bit [63:0] rsq;
        bit [63:0] t;
        bit [63:0] t24;
        bit [63:0] b;
        bit [63:0] c;
        bit [63:0] inv;
        bit [127:0] p;
        dx = x - tbl_cx[i];
        dy = y - tbl_cy[i];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx >= (64'd1 << 24) || dy >= (64'd1 << 24)) return 0;
        inv = tbl_inv[i];
        rsq = dx * dx + dy * dy;
        p = rsq * inv;
        if (p >= (128'd1 << 48)) return 0;
        t = (64'd1 << 48) - p[63:0];
        t24 = (t + (64'd1 << 23)) >> 24;
        b = (t24 * inv + (64'd1 << 31)) >> 32;
        c = (b * 64'hA2F9836E + (64'd1 << 31)) >> 32;
        return (c * tbl_mass[i] + (64'd1 << 11)) >> 12;
    endfunction

    // apply one item to the table copy and return its result
    function automatic density_result_t predict_density(blob_item_t it);
        density_result_t r;
        longint    x;
        longint    y;
        longint    sum;
        longint    term;
        bit [63:0] wsq;
        bit [63:0] inv;
        longint    smax;
        x = longint'(signed'(it.px));
        y = longint'(signed'(it.py));
        smax = (64'sd1 <<< 47) - 1;
        r.saturated = 0;
        sum = 0;
        if (!it.command) begin
            wsq = it.width * it.width;
            inv = 64'hFFFFFFFF;
            if (wsq != 0) inv = ((64'd1 << 48) + wsq / 2) / wsq;
            if (wsq == 0 || inv > 64'hFFFFFFFF) begin
                inv = 64'hFFFFFFFF;
                r.saturated = 1;
            end
            if (tbl_en[it.index]) live_count--;
            if (it.enable) live_count++;
            tbl_cx[it.index] = x;
            tbl_cy[it.index] = y;
            tbl_mass[it.index] = it.mass;
            tbl_inv[it.index] = inv[31:0];
            tbl_en[it.index] = it.enable;
            tbl_neg[it.index] = it.negative;
        end else begin
            for (int i = 0; i < 128; i++) begin
                if (!tbl_en[i]) continue;
                term = longint'(blob_magnitude(i, x, y));
                if (tbl_neg[i]) term = -term;
                sum += term;
                if (sum > smax) begin
                    sum = smax;
                    r.saturated = 1;
                end
                if (sum < -smax - 1) begin
                    sum = -smax - 1;
                    r.saturated = 1;
                end
            end
        end
        r.density = sum[47:0];
        r.active = live_count[7:0];
        return r;
    endfunction

    function automatic blob_item_t rand_write(int idx, bit near);
        blob_item_t it;
        it.command = 0;
        it.index = idx[6:0];
        it.enable = ($urandom_range(0, 9) != 0);
        it.negative = 1'($urandom_range(0, 1));
        it.mass = (near) ? 24'($urandom_range(1, 24'hFFFF) << $urandom_range(0, 8))
                         : 24'($urandom);
        it.width = (near) ? 24'($urandom_range(1, 24'h3FFF) << $urandom_range(0, 6))
                          : 24'($urandom);
        if (it.width == 0) it.width = 1;
        it.px = (near) ? 24'($signed($urandom_range(0, 24'h3FFFF)) - 24'sh1FFFF)
                       : 24'($urandom);
        it.py = (near) ? 24'($signed($urandom_range(0, 24'h3FFFF)) - 24'sh1FFFF)
                       : 24'($urandom);
        return it;
    endfunction

    function automatic blob_item_t rand_eval(bit near);
        blob_item_t it;
        it = rand_write($urandom_range(0, 127), near);
        it.command = 1;
        return it;
    endfunction

    function automatic blob_item_t make_item(bit cmd, int idx, bit en, bit neg,
                                             bit [23:0] x, bit [23:0] y,
                                             bit [23:0] m, bit [23:0] w);
        blob_item_t it;
        it.command = cmd; it.index = idx[6:0]; it.enable = en; it.negative = neg;
        it.px = x; it.py = y; it.mass = m; it.width = w;
        return it;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_items.size() > 0 && !send_pause &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                blob_item_t it;
                it = pending_items.pop_front();
                expected_results.push_back(predict_density(it));
                in_ch.valid          <= 1;
                in_ch.command        <= it.command;
                in_ch.entry_index    <= it.index;
                in_ch.entry_enable   <= it.enable;
                in_ch.entry_negative <= it.negative;
                in_ch.pos_x          <= it.px;
                in_ch.pos_y          <= it.py;
                in_ch.entry_mass     <= it.mass;
                in_ch.entry_width    <= it.width;
            end else begin
                in_ch.valid <= 0;
            end
        end
    end

    // result ready, with long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready <= 0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
            end else begin
                density_result_t e;
                e = expected_results.pop_front();
                if (out_ch.density !== e.density || out_ch.saturated !== e.saturated ||
                    out_ch.active_entries !== e.active) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp d=%h s=%b n=%0d got d=%h s=%b n=%0d",
                                 e.density, e.saturated, e.active, out_ch.density,
                                 out_ch.saturated, out_ch.active_entries);
                end
            end
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_results.size() > 0 || in_ch.valid)
            @(posedge i_clk);
    endtask

    task automatic add_phase(int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 2) == 0)
                pending_items.push_back(rand_write($urandom_range(0, 127),
                                                   $urandom_range(0, 7) != 0));
            else
                pending_items.push_back(rand_eval($urandom_range(0, 7) != 0));
        end
    endtask

    initial begin
        in_ch.valid = 0; in_ch.command = 0; in_ch.entry_index = 0;
        in_ch.entry_enable = 0; in_ch.entry_negative = 0; in_ch.pos_x = 0;
        in_ch.pos_y = 0; in_ch.entry_mass = 0; in_ch.entry_width = 0;
        out_ch.ready = 0;
        live_count = 0; mismatches = 0; cycle_count = 0; hold_off_cycles = 0;
        send_pause = 0;
        foreach (tbl_en[i]) begin
            tbl_en[i] = 0; tbl_neg[i] = 0;
        end
        send_idle_pct = 9;
        recv_idle_pct = 59;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, width-one blobs, far points, saturation
        pending_items.push_back(make_item(1, 0, 0, 0, 0, 0, 0, 1));
        pending_items.push_back(make_item(0, 0, 1, 0, 0, 0, 24'hFFFFFF, 1));
        pending_items.push_back(make_item(0, 1, 1, 0, 0, 0, 24'hFFFFFF, 24'h000FFF));
        pending_items.push_back(make_item(0, 2, 1, 1, 24'h7FFFFF, 24'h800000,
                                          24'h001000, 24'hFFFFFF));
        pending_items.push_back(make_item(0, 127, 1, 0, 24'h800000, 24'h7FFFFF,
                                          24'hFFFFFF, 24'h000100));
        pending_items.push_back(make_item(1, 0, 0, 0, 0, 0, 0, 1));
        pending_items.push_back(make_item(1, 0, 0, 0, 24'h000010, 24'hFFFFF0, 0, 1));
        pending_items.push_back(make_item(1, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 0, 1));
        pending_items.push_back(make_item(1, 0, 0, 0, 24'h800000, 24'h800000, 0, 1));
        pending_items.push_back(make_item(1, 0, 0, 0, 24'h7FFFFF, 24'h800000, 0, 1));
        for (int i = 3; i < 10; i++)
            pending_items.push_back(make_item(0, i, 1, 0, 0, 0, 24'hFFFFFF, 1));
        pending_items.push_back(make_item(1, 0, 0, 0, 0, 0, 0, 1));
        pending_items.push_back(make_item(0, 0, 0, 1, 0, 0, 0, 24'hFFFFFF));
        pending_items.push_back(make_item(0, 1, 1, 1, 24'h000800, 0, 24'h000001, 24'h002000));
        pending_items.push_back(make_item(1, 0, 0, 0, 24'h000400, 0, 0, 1));
        wait_drained();

        // long receiver stall while the sender keeps pushing
        hold_off_cycles = 1500;
        add_phase(40);
        wait_drained();

        // sender pause once everything has come back
        add_phase(80);
        wait_drained();
        send_pause = 1;
        repeat (50) @(posedge i_clk);
        send_pause = 0;
        add_phase(40);
        wait_drained();

        send_idle_pct = 59;
        recv_idle_pct = 9;
        add_phase(140);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_phase(130);
        wait_drained();

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
